// File: design/todbs_pkg.sv
package todbs_pkg;

	localparam int SEC_W  = 17;
	localparam int LVL_W  = 8;
	localparam int PROD_W = SEC_W + LVL_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int SUM_W  = NUM_W + 1;
	localparam int STEP_W = $clog2(LVL_W);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [SEC_W-1:0] SECS_PER_DAY    = 17'd86400;
	localparam logic [SEC_W-1:0] SECS_PER_HOUR   = 17'd3600;
	localparam logic [SEC_W-1:0] SECS_PER_MINUTE = 17'd60;
	localparam logic [LVL_W-1:0] NO_WINDOW_LEVEL = 8'd255;
	localparam logic [LVL_W-1:0] MAX_LEVEL       = 8'd255;

	localparam logic [SEC_W-1:0] RST_BRIGHT_START = 17'd25200;
	localparam logic [SEC_W-1:0] RST_BRIGHT_END   = 17'd75600;
	localparam logic [SEC_W-1:0] RST_DIM_START    = 17'd79200;
	localparam logic [SEC_W-1:0] RST_DIM_END      = 17'd21600;
	localparam logic [LVL_W-1:0] RST_NORMAL_LEVEL = 8'd255;
	localparam logic [LVL_W-1:0] RST_DIM_LEVEL    = 8'd16;
	localparam logic [LVL_W-1:0] RST_GRAD_THRESH  = 8'd64;

	typedef enum logic [2:0] {
		REG_BRIGHT_START = 3'd0,
		REG_BRIGHT_END   = 3'd1,
		REG_DIM_START    = 3'd2,
		REG_DIM_END      = 3'd3,
		REG_NORMAL_LEVEL = 3'd4,
		REG_DIM_LEVEL    = 3'd5,
		REG_GRAD_THRESH  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SEC_W-1:0] bright_start_sec;
		logic [SEC_W-1:0] bright_end_sec;
		logic [SEC_W-1:0] dim_start_sec;
		logic [SEC_W-1:0] dim_end_sec;
		logic [LVL_W-1:0] normal_level;
		logic [LVL_W-1:0] dim_level;
		logic [LVL_W-1:0] gradient_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		WIN_BRIGHT,
		WIN_DIM,
		WIN_DIMMING,
		WIN_BRIGHTENING,
		WIN_NONE
	} win_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIFF,
		ST_RAMP,
		ST_MUL,
		ST_SUM,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic in_window(input logic [SEC_W-1:0] t,
			input logic [SEC_W-1:0] lo, input logic [SEC_W-1:0] hi);
		if (lo <= hi) begin
			return (t >= lo) && (t <= hi);
		end
		return (t <= hi) || (t >= lo);
	endfunction

	// Inputs stay below twice a day, so one subtraction reduces them.
	function automatic logic [SEC_W-1:0] mod_day(input logic [SEC_W-1:0] v);
		return (v >= SECS_PER_DAY) ? v - SECS_PER_DAY : v;
	endfunction

	function automatic logic [SEC_W-1:0] day_diff(input logic [SEC_W-1:0] a,
			input logic [SEC_W-1:0] b);
		logic [SEC_W:0] diff;
		diff = {1'b0, a} - {1'b0, b};
		if (diff[SEC_W]) begin
			diff = diff + {1'b0, SECS_PER_DAY};
		end
		return diff[SEC_W-1:0];
	endfunction

endpackage

// File: design/todbs_if.sv
interface todbs_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] hour_of_day;
	logic [5:0] minute_of_hour;
	logic [5:0] second_of_minute;

	modport source (output valid, hour_of_day, minute_of_hour, second_of_minute, input ready);
	modport sink (input valid, hour_of_day, minute_of_hour, second_of_minute, output ready);
endinterface

interface todbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] level;
	logic       level_changed;
	logic       threshold_crossed;

	modport source (output valid, level, level_changed, threshold_crossed, input ready);
	modport sink (input valid, level, level_changed, threshold_crossed, output ready);
endinterface

// File: design/todbs_regs.sv
module todbs_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [todbs_pkg::ADDR_W-1:0]   paddr,
	input  logic [todbs_pkg::DATA_W-1:0]   pwdata,
	output logic [todbs_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	output todbs_pkg::cfg_t                cfg
);
	import todbs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_start_sec   <= RST_BRIGHT_START;
			cfg_q.bright_end_sec     <= RST_BRIGHT_END;
			cfg_q.dim_start_sec      <= RST_DIM_START;
			cfg_q.dim_end_sec        <= RST_DIM_END;
			cfg_q.normal_level       <= RST_NORMAL_LEVEL;
			cfg_q.dim_level          <= RST_DIM_LEVEL;
			cfg_q.gradient_threshold <= RST_GRAD_THRESH;
		end else if (wr_en) begin
			unique case (idx)
				REG_BRIGHT_START: cfg_q.bright_start_sec   <= pwdata[SEC_W-1:0];
				REG_BRIGHT_END:   cfg_q.bright_end_sec     <= pwdata[SEC_W-1:0];
				REG_DIM_START:    cfg_q.dim_start_sec      <= pwdata[SEC_W-1:0];
				REG_DIM_END:      cfg_q.dim_end_sec        <= pwdata[SEC_W-1:0];
				REG_NORMAL_LEVEL: cfg_q.normal_level       <= pwdata[LVL_W-1:0];
				REG_DIM_LEVEL:    cfg_q.dim_level          <= pwdata[LVL_W-1:0];
				REG_GRAD_THRESH:  cfg_q.gradient_threshold <= pwdata[LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BRIGHT_START: prdata = DATA_W'(cfg_q.bright_start_sec);
			REG_BRIGHT_END:   prdata = DATA_W'(cfg_q.bright_end_sec);
			REG_DIM_START:    prdata = DATA_W'(cfg_q.dim_start_sec);
			REG_DIM_END:      prdata = DATA_W'(cfg_q.dim_end_sec);
			REG_NORMAL_LEVEL: prdata = DATA_W'(cfg_q.normal_level);
			REG_DIM_LEVEL:    prdata = DATA_W'(cfg_q.dim_level);
			REG_GRAD_THRESH:  prdata = DATA_W'(cfg_q.gradient_threshold);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: design/todbs_mul.sv
module todbs_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [todbs_pkg::LVL_W-1:0]   mplier,
	input  logic [todbs_pkg::SEC_W-1:0]   mcand,
	output logic [todbs_pkg::PROD_W-1:0]  product,
	output logic                          done
);
	import todbs_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LVL_W - 1);

	logic [LVL_W-1:0]  mplier_q;
	logic [PROD_W-1:0] mcand_q;
	logic [PROD_W-1:0] acc_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	// One multiplier bit per cycle, least significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			mplier_q <= mplier;
			mcand_q  <= PROD_W'(mcand);
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mplier_q <= mplier_q >> 1;
			mcand_q  <= mcand_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

// File: design/todbs_div.sv
module todbs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [todbs_pkg::NUM_W-1:0]  num,
	input  logic [todbs_pkg::SEC_W-1:0]  den,
	output logic [todbs_pkg::LVL_W-1:0]  quot,
	output logic                         done
);
	import todbs_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LVL_W - 1);

	logic [NUM_W-1:0]  rem_q;
	logic [PROD_W-1:0] dv_q;
	logic [LVL_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	// The divisor is twice den, aligned to the top quotient bit.
	assign fits = rem_q >= NUM_W'(dv_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dv_q   <= {den, {LVL_W{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - NUM_W'(dv_q);
			end
			quot_q <= {quot_q[LVL_W-2:0], fits};
			dv_q   <= dv_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

// File: design/time_of_day_brightness_schedule.sv
// Brightness schedule: each time-of-day transaction is mapped to one panel level. A time in the
// bright or dim window or in no window goes from acceptance through the classify and difference
// states straight to the done state; a time on a ramp also runs the bit-serial multipliers and
// the restoring divider that compute the rounded ramp level exactly. A ramp of zero duration
// skips the multipliers and the divider, and a ramp value that saturates skips the divider.
// One time is processed at a time; the next is accepted as soon as the previous result has moved
// into the output register, even while that result still waits to be taken. Registers are written
// over the APB port at byte address 4*i and should only be changed while the block is idle.
module time_of_day_brightness_schedule (
	input  logic                          clk,
	input  logic                          arst_n,
	todbs_in_if.sink                      time_in,
	todbs_out_if.source                   level_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [todbs_pkg::ADDR_W-1:0]  paddr,
	input  logic [todbs_pkg::DATA_W-1:0]  pwdata,
	output logic [todbs_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);
	import todbs_pkg::*;

	cfg_t cfg;

	state_t state_q;
	state_t state_d;

	logic              in_fire;
	logic              mul_start;
	logic              div_start;
	logic              out_load;
	logic [SEC_W-1:0]  tod_next;

	logic [SEC_W-1:0]  tod_q;
	logic [SEC_W-1:0]  tm_q;
	logic [SEC_W-1:0]  rsm_q;
	logic [SEC_W-1:0]  rem_q;
	logic [SEC_W-1:0]  e_q;
	logic [SEC_W-1:0]  d_q;
	logic [LVL_W-1:0]  from_q;
	logic [LVL_W-1:0]  to_q;
	win_t              win_q;
	logic [SUM_W-1:0]  n_q;
	logic [LVL_W-1:0]  lvl_q;

	win_t              win_sel;
	logic [SEC_W-1:0]  rs_sel;
	logic [SEC_W-1:0]  re_sel;
	logic [LVL_W-1:0]  from_sel;
	logic [LVL_W-1:0]  to_sel;

	logic              ramp_neg;
	logic [LVL_W-1:0]  ramp_mag;
	logic [PROD_W-1:0] p_base;
	logic [PROD_W-1:0] p_slope;
	logic              mul_done_a;
	logic              mul_done_b;
	logic [SUM_W-1:0]  n_next;
	logic              n_over;
	logic [LVL_W-1:0]  div_quot;
	logic              div_done;

	logic              out_valid_q;
	logic [LVL_W-1:0]  out_level_q;
	logic              out_changed_q;
	logic              out_crossed_q;
	logic [LVL_W-1:0]  applied_q;
	logic              lvl_changed;
	logic              lvl_crossed;

	todbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign time_in.ready = (state_q == ST_IDLE);
	assign in_fire       = time_in.valid && time_in.ready;

	assign tod_next = SEC_W'(time_in.hour_of_day) * SECS_PER_HOUR
		+ SEC_W'(time_in.minute_of_hour) * SECS_PER_MINUTE
		+ SEC_W'(time_in.second_of_minute);

	always_comb begin
		win_sel  = WIN_NONE;
		rs_sel   = cfg.dim_end_sec;
		re_sel   = cfg.bright_start_sec;
		from_sel = cfg.dim_level;
		to_sel   = cfg.normal_level;
		priority if (in_window(tod_q, cfg.bright_start_sec, cfg.bright_end_sec)) begin
			win_sel = WIN_BRIGHT;
		end else if (in_window(tod_q, cfg.dim_start_sec, cfg.dim_end_sec)) begin
			win_sel = WIN_DIM;
		end else if (in_window(tod_q, cfg.bright_end_sec, cfg.dim_start_sec)) begin
			win_sel  = WIN_DIMMING;
			rs_sel   = cfg.bright_end_sec;
			re_sel   = cfg.dim_start_sec;
			from_sel = cfg.normal_level;
			to_sel   = cfg.dim_level;
		end else if (in_window(tod_q, cfg.dim_end_sec, cfg.bright_start_sec)) begin
			win_sel = WIN_BRIGHTENING;
		end else begin
			win_sel = WIN_NONE;
		end
	end

	assign ramp_neg = to_q < from_q;
	assign ramp_mag = ramp_neg ? from_q - to_q : to_q - from_q;

	todbs_mul u_mul_base (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mplier  (from_q),
		.mcand   (d_q),
		.product (p_base),
		.done    (mul_done_a)
	);

	todbs_mul u_mul_slope (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mplier  (ramp_mag),
		.mcand   (e_q),
		.product (p_slope),
		.done    (mul_done_b)
	);

	// Numerator of the rounded ramp value: 2*from*d + 2*(to-from)*e + d.
	always_comb begin
		n_next = {2'b00, p_base, 1'b0} + SUM_W'(d_q);
		if (ramp_neg) begin
			n_next = n_next - {2'b00, p_slope, 1'b0};
		end else begin
			n_next = n_next + {2'b00, p_slope, 1'b0};
		end
	end

	assign n_over = n_q[NUM_W-1:0] >= {1'b0, d_q, {(LVL_W + 1){1'b0}}};

	todbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (n_q[NUM_W-1:0]),
		.den    (d_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				if (win_q == WIN_DIMMING || win_q == WIN_BRIGHTENING) begin
					state_d = ST_RAMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RAMP: begin
				if (d_q == '0) begin
					state_d = ST_DONE;
				end else begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done_a && mul_done_b) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (n_q[SUM_W-1] || n_over) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || level_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tod_q <= tod_next;
		end
		if (state_q == ST_CLASS) begin
			tm_q   <= mod_day(tod_q);
			rsm_q  <= mod_day(rs_sel);
			rem_q  <= mod_day(re_sel);
			from_q <= from_sel;
			to_q   <= to_sel;
			win_q  <= win_sel;
		end
		if (state_q == ST_DIFF) begin
			e_q <= day_diff(tm_q, rsm_q);
			d_q <= day_diff(rem_q, rsm_q);
			unique case (win_q)
				WIN_BRIGHT: lvl_q <= cfg.normal_level;
				WIN_DIM:    lvl_q <= cfg.dim_level;
				default:    lvl_q <= NO_WINDOW_LEVEL;
			endcase
		end
		if (state_q == ST_RAMP && d_q == '0) begin
			lvl_q <= to_q;
		end
		if (state_q == ST_SUM) begin
			n_q <= n_next;
		end
		if (state_q == ST_CHECK) begin
			if (n_q[SUM_W-1]) begin
				lvl_q <= '0;
			end else if (n_over) begin
				lvl_q <= MAX_LEVEL;
			end
		end
		if (state_q == ST_DIV && div_done) begin
			lvl_q <= div_quot;
		end
	end

	assign lvl_changed = lvl_q != applied_q;
	assign lvl_crossed = lvl_changed
		&& ((applied_q <= cfg.gradient_threshold) != (lvl_q <= cfg.gradient_threshold));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			applied_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				applied_q   <= lvl_q;
			end else if (level_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q   <= lvl_q;
			out_changed_q <= lvl_changed;
			out_crossed_q <= lvl_crossed;
		end
	end

	assign level_out.valid             = out_valid_q;
	assign level_out.level             = out_level_q;
	assign level_out.level_changed     = out_changed_q;
	assign level_out.threshold_crossed = out_crossed_q;

	a_cross_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		level_out.valid |-> (!level_out.threshold_crossed || level_out.level_changed))
		else $error("threshold crossing reported without a level change");

	a_applied_matches: assert property (@(posedge clk) disable iff (!arst_n)
		level_out.valid |-> (applied_q == level_out.level))
		else $error("applied level differs from the level shown");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_a == mul_done_b)
		else $error("ramp multipliers out of step");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

endmodule
